// ----- src/bdq_pkg.sv -----
// ----------------------------------------------------------------------------
// bdq_pkg
// Shared types and constants for the bounded deque with indexed read.
// ----------------------------------------------------------------------------
package bdq_pkg;

    // Store geometry
    localparam int CAPACITY      = 256;
    localparam int ELEMENT_WIDTH = 32;
    localparam int PTR_W         = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W         = $clog2(CAPACITY + 1);

    // Port field widths
    localparam int ACTION_W = 3;
    localparam int VALUE_W  = 32;
    localparam int POS_W    = 8;
    localparam int COUNT_W  = 9;
    localparam int STATUS_W = 2;

    // Request codes
    typedef enum logic [ACTION_W-1:0] {
        ACT_INSERT_HEAD = 3'd0,
        ACT_INSERT_TAIL = 3'd1,
        ACT_REMOVE_HEAD = 3'd2,
        ACT_REMOVE_TAIL = 3'd3,
        ACT_READ_HEAD   = 3'd4,
        ACT_READ_TAIL   = 3'd5,
        ACT_READ_INDEX  = 3'd6
    } action_t;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_RANGE = 2'd3
    } status_t;

endpackage

// ----- src/bounded_deque_with_indexed_read_top.sv -----
// ----------------------------------------------------------------------------
// bounded_deque_with_indexed_read_top
// Circular-store double-ended queue with head/tail insert, remove and read,
// plus a read at any position counted from the head.
// ----------------------------------------------------------------------------
// Every request gives exactly one result: read value, count held afterwards
// and a status. One request is taken per cycle when in_stall is low; a result
// goes through the store access stage and then the output register once its
// request is taken, the access stage using the registered read port of the
// single element memory. Head pointer and count are updated as the request
// is taken, so the next request sees them at once. in_stall rises only
// when a result is held in the output register and a second one waits
// behind it. The store has no reset; only written entries are ever read.
// ----------------------------------------------------------------------------
module bounded_deque_with_indexed_read_top
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [bdq_pkg::ACTION_W-1:0]    action,
    input  logic [bdq_pkg::VALUE_W-1:0]     element_value,
    input  logic [bdq_pkg::POS_W-1:0]       position,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [bdq_pkg::VALUE_W-1:0]     read_value,
    output logic [bdq_pkg::COUNT_W-1:0]     item_count,
    output logic [bdq_pkg::STATUS_W-1:0]    status
);
    import bdq_pkg::*;

    // Slot of head + offset, wrapped once round the store
    function automatic logic [PTR_W-1:0] slot_wrap(input logic [PTR_W-1:0] base,
                                                   input logic [PTR_W-1:0] offset);
        logic [PTR_W:0] sum;
        sum = {1'b0, base} + {1'b0, offset};
        if (sum >= (PTR_W+1)'(CAPACITY))
        begin
            sum = sum - (PTR_W+1)'(CAPACITY);
        end
        return sum[PTR_W-1:0];
    endfunction

    // State
    logic [PTR_W-1:0]          head_reg, head_next;
    logic [CNT_W-1:0]          count_reg, count_next;

    // Element store
    logic [ELEMENT_WIDTH-1:0]  mem [CAPACITY];
    logic [ELEMENT_WIDTH-1:0]  rd_data_reg;

    // Access stage
    logic                      s1_valid_reg;
    logic                      s1_is_read_reg;
    logic [CNT_W-1:0]          s1_count_reg;
    status_t                   s1_status_reg;

    // Output register
    logic                      out_valid_reg;
    logic [VALUE_W-1:0]        read_value_reg;
    logic [COUNT_W-1:0]        item_count_reg;
    status_t                   status_reg;

    // Request decode
    action_t                   act;
    logic                      accept;
    logic                      s1_move;
    logic                      out_free;
    logic                      is_full;
    logic                      is_empty;
    logic [PTR_W-1:0]          offset;
    logic [PTR_W-1:0]          head_dec;
    logic [PTR_W-1:0]          addr;
    logic                      mem_we;
    logic                      mem_re;
    status_t                   req_status;

    // Handshake
    assign out_free = !out_valid_reg || !out_stall;
    assign s1_move  = s1_valid_reg && out_free;
    assign in_stall = s1_valid_reg && !out_free;
    assign accept   = in_valid && !in_stall;

    assign act      = action_t'(action);
    assign is_full  = (count_reg == CNT_W'(CAPACITY));
    assign is_empty = (count_reg == '0);
    assign head_dec = (head_reg == '0) ? PTR_W'(CAPACITY - 1) : head_reg - 1'b1;

    // Offset from head for the addressed slot
    always_comb
    begin
        unique case (act)
            ACT_INSERT_TAIL: offset = PTR_W'(count_reg);
            ACT_READ_TAIL:   offset = PTR_W'(count_reg - 1'b1);
            ACT_READ_INDEX:  offset = PTR_W'(position);
            default:         offset = '0;
        endcase
    end

    // Status, pointer updates and store access
    always_comb
    begin
        head_next  = head_reg;
        count_next = count_reg;
        req_status = ST_OK;
        mem_we     = 1'b0;
        mem_re     = 1'b0;
        addr       = slot_wrap(head_reg, offset);
        unique case (act)
            ACT_INSERT_HEAD:
            begin
                addr = head_dec;
                if (is_full)
                begin
                    req_status = ST_FULL;
                end
                else
                begin
                    head_next  = head_dec;
                    count_next = count_reg + 1'b1;
                    mem_we     = 1'b1;
                end
            end
            ACT_INSERT_TAIL:
            begin
                if (is_full)
                begin
                    req_status = ST_FULL;
                end
                else
                begin
                    count_next = count_reg + 1'b1;
                    mem_we     = 1'b1;
                end
            end
            ACT_REMOVE_HEAD:
            begin
                if (is_empty)
                begin
                    req_status = ST_EMPTY;
                end
                else
                begin
                    head_next  = slot_wrap(head_reg, PTR_W'(1));
                    count_next = count_reg - 1'b1;
                end
            end
            ACT_REMOVE_TAIL:
            begin
                if (is_empty)
                begin
                    req_status = ST_EMPTY;
                end
                else
                begin
                    count_next = count_reg - 1'b1;
                end
            end
            ACT_READ_HEAD, ACT_READ_TAIL:
            begin
                if (is_empty)
                begin
                    req_status = ST_EMPTY;
                end
                else
                begin
                    mem_re = 1'b1;
                end
            end
            ACT_READ_INDEX:
            begin
                if (is_empty)
                begin
                    req_status = ST_EMPTY;
                end
                else if (32'(position) >= 32'(count_reg))
                begin
                    req_status = ST_RANGE;
                end
                else
                begin
                    mem_re = 1'b1;
                end
            end
            default:
            begin
                req_status = ST_OK;
            end
        endcase
    end

    // Element memory: one write or one registered read per request
    always_ff @(posedge clk)
    begin
        if (accept && mem_we)
        begin
            mem[addr] <= ELEMENT_WIDTH'(element_value);
        end
        if (accept && mem_re)
        begin
            rd_data_reg <= mem[addr];
        end
    end

    // Head pointer and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            count_reg <= '0;
        end
        else if (accept)
        begin
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

    // Access stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_move)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    // Access stage payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_is_read_reg <= mem_re;
            s1_count_reg   <= count_next;
            s1_status_reg  <= req_status;
        end
    end

    // Output register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    // Output register payload
    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            read_value_reg <= s1_is_read_reg ? VALUE_W'(rd_data_reg) : '0;
            item_count_reg <= COUNT_W'(s1_count_reg);
            status_reg     <= s1_status_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign read_value = read_value_reg;
    assign item_count = item_count_reg;
    assign status     = status_reg;

endmodule

// ----- src/bdq_checker.sv -----
// ----------------------------------------------------------------------------
// bdq_checker
// Port-level checks on the deque results, bound to the top level.
// ----------------------------------------------------------------------------
module bdq_checker
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            out_valid,
    input  logic                            out_stall,
    input  logic [bdq_pkg::VALUE_W-1:0]     read_value,
    input  logic [bdq_pkg::COUNT_W-1:0]     item_count,
    input  logic [bdq_pkg::STATUS_W-1:0]    status
);
    import bdq_pkg::*;

    // A stalled result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(read_value)
                                   && $stable(item_count) && $stable(status))
        else $error("stalled result changed");

    // Count never exceeds capacity
    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> 32'(item_count) <= 32'(CAPACITY))
        else $error("count above capacity");

    // Refused insert only when full, with no read value
    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_FULL |->
            32'(item_count) == 32'(CAPACITY) && read_value == '0)
        else $error("full status with wrong count or value");

    // Empty status leaves an empty list and a zero value
    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_EMPTY |-> item_count == '0 && read_value == '0)
        else $error("empty status with wrong count or value");

    // Out of range read on a non-empty list gives zero
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_RANGE |-> item_count != '0 && read_value == '0)
        else $error("range status with wrong count or value");

endmodule

bind bounded_deque_with_indexed_read_top bdq_checker u_bdq_checker
(
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .read_value (read_value),
    .item_count (item_count),
    .status     (status)
);
